FILE: rtl/nme_pkg.sv
package nme_pkg;

  // Configuration register indexes.
  localparam int REG_IDX_W = 2;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_ECHO_DELAY = 2'd0;
  localparam reg_idx_t REG_ECHO_GAIN  = 2'd1;
  localparam reg_idx_t REG_TAP_COUNT  = 2'd2;

  // Register field widths; the write data is as wide as the widest one.
  localparam int DELAY_W    = 11;
  localparam int GAIN_W     = 16;
  localparam int TAPCNT_W   = 4;
  localparam int CFG_DATA_W = 16;

  typedef logic [DELAY_W-1:0]  delay_t;
  typedef logic [GAIN_W-1:0]   gain_t;
  typedef logic [TAPCNT_W-1:0] tapcnt_t;

  // Register values after reset.
  localparam delay_t  DELAY_RST = 11'd441;
  localparam gain_t   GAIN_RST  = 16'd6554;
  localparam tapcnt_t TAPS_RST  = 4'd1;

  // Unity in Q15 and its position.
  localparam gain_t Q15_ONE   = 16'd32768;
  localparam int    Q15_SHIFT = 15;

endpackage

FILE: rtl/nme_ram.sv
module nme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/nme_div.sv
module nme_div #(
  parameter int SAMPLE_BITS = 16,
  parameter int DEN_W       = 19
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [SAMPLE_BITS+DEN_W-1:0] num,
  input  logic [DEN_W-1:0]                den,
  output logic                            done,
  output logic signed [SAMPLE_BITS-1:0]   quot
);

  import nme_pkg::*;

  localparam int NUM_W = SAMPLE_BITS + DEN_W;
  localparam int DSH_W = DEN_W + SAMPLE_BITS - 1;
  localparam int CNT_W = $clog2(SAMPLE_BITS);

  logic [NUM_W-1:0]       rem_r;
  logic [DSH_W-1:0]       dsh_r;
  logic [SAMPLE_BITS-1:0] q_r;
  logic                   neg_r;
  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;

  logic [NUM_W-1:0]         num_mag;
  logic                     ge;
  logic signed [SAMPLE_BITS:0] q_s;

  // The quotient magnitude stays below 2^SAMPLE_BITS because the result is a
  // weighted mean of samples, so one restoring step per quotient bit suffices.
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign ge      = rem_r >= NUM_W'(dsh_r);

  // Restoring division on magnitudes, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SAMPLE_BITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num_mag;
      dsh_r <= DSH_W'(den) << (SAMPLE_BITS - 1);
      q_r   <= '0;
      neg_r <= num[NUM_W-1];
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - NUM_W'(dsh_r);
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[SAMPLE_BITS-2:0], ge};
    end
  end

  // Apply the sign and clamp to the sample range.
  always_comb begin
    q_s = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    if (q_s > $signed((SAMPLE_BITS+1)'((1 << (SAMPLE_BITS - 1)) - 1))) begin
      quot = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (q_s < -$signed((SAMPLE_BITS+1)'(1 << (SAMPLE_BITS - 1)))) begin
      quot = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      quot = q_s[SAMPLE_BITS-1:0];
    end
  end

  assign done = done_r;

endmodule

FILE: rtl/normalized_multitap_echo_core.sv
// Channel | Direction | Beat contents (lowest bit first)
// in_     | slave     | tdata: channel, sample_in, zero fill to whole bytes
// out_    | master    | tdata: channel_out, sample_out, zero fill to whole bytes
// cfg_    | write     | cfg_index selects echo_delay, echo_gain or tap_count
//
// Each tap of a beat takes a read state and an accumulate state, since the
// history memory read is registered, and the divider gives one quotient bit
// per cycle. After reset the history memory is cleared, one entry a cycle,
// over all CHANNELS*HISTORY_DEPTH entries (32768 with the defaults), and
// in_tready stays low meanwhile. A finished beat waits in the output register
// while the next input beat is taken; a stall on out_tready holds only the end
// of the following beat.
module normalized_multitap_echo_core #(
  parameter int CHANNELS      = 2,
  parameter int HISTORY_DEPTH = 16384,
  parameter int MAX_TAPS      = 8,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // channel, sample_in
  input  logic [((SAMPLE_BITS+8)/8)*8-1:0]        in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // channel_out, sample_out
  output logic [((SAMPLE_BITS+8)/8)*8-1:0]        out_tdata,
  input  logic                                   cfg_we,
  input  nme_pkg::reg_idx_t                      cfg_index,
  input  logic [nme_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  import nme_pkg::*;

  localparam int DATA_W    = ((SAMPLE_BITS + 8) / 8) * 8;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW        = $clog2(HISTORY_DEPTH);
  localparam int SUM_W     = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
  localparam int MEM_DEPTH = CHANNELS * HISTORY_DEPTH;
  localparam int MAW       = $clog2(MEM_DEPTH);
  localparam int TAP_W     = $clog2(MAX_TAPS + 1);
  localparam int TC_W      = ((TAP_W > TAPCNT_W) ? TAP_W : TAPCNT_W) + 1;
  localparam int DEN_W     = Q15_SHIFT + $clog2(MAX_TAPS + 2);
  localparam int NUM_W     = SAMPLE_BITS + DEN_W;
  localparam int PROD_W    = SAMPLE_BITS + GAIN_W + 1;

  // Sequencer states.
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_WR   = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_DVS  = 3'd5;
  localparam logic [2:0] ST_DVW  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  // Configuration registers.
  delay_t  delay_r;
  gain_t   gain_r;
  tapcnt_t taps_r;

  // Control and working registers.
  logic [2:0]             st_r;
  logic [MAW-1:0]         clr_addr_r;
  logic [AW-1:0]          wp_r [CHANNELS];
  logic [CH_W-1:0]        ch_r;
  logic                   chf_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [AW-1:0]          wpc_r;
  logic [AW-1:0]          lag_r;
  logic [AW-1:0]          dly_r;
  logic [TAP_W-1:0]       j_r;
  logic [TAP_W-1:0]       ntap_r;
  gain_t                  g_r;
  gain_t                  p_r;
  logic signed [NUM_W-1:0] num_r;
  logic [DEN_W-1:0]       den_r;
  logic                   out_valid_r;
  logic                   out_ch_r;
  logic signed [SAMPLE_BITS-1:0] out_smp_r;

  // Combinational helpers.
  logic                   in_ch;
  logic signed [SAMPLE_BITS-1:0] in_smp;
  logic                   accept;
  logic                   out_free;
  gain_t                  g_sat;
  logic [TAP_W-1:0]       ntap;
  logic [SUM_W-1:0]       dly_mod;
  logic [SUM_W-1:0]       lag_sum;
  logic [AW-1:0]          lag_nxt;
  logic [SUM_W-1:0]       idx;
  logic [AW-1:0]          wp_nxt;
  logic [MAW-1:0]         base;
  logic                   mem_we;
  logic [MAW-1:0]         mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic [MAW-1:0]         mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_rdata;
  logic [2*GAIN_W-1:0]    pg;
  logic signed [PROD_W-1:0] tap_prod;
  logic                   div_done;
  logic signed [SAMPLE_BITS-1:0] div_quot;

  assign in_ch    = in_tdata[0];
  assign in_smp   = in_tdata[SAMPLE_BITS:1];
  assign in_tready = (st_r == ST_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Configuration writes land at once; no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RST;
      gain_r  <= GAIN_RST;
      taps_r  <= TAPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ECHO_DELAY: delay_r <= cfg_wdata[DELAY_W-1:0];
        REG_ECHO_GAIN:  gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_TAP_COUNT:  taps_r  <= cfg_wdata[TAPCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective gain, tap count and tap spacing within one channel region.
  always_comb begin
    g_sat = (gain_r > Q15_ONE) ? Q15_ONE : gain_r;
    if (taps_r == '0) begin
      ntap = TAP_W'(1);
    end else if (TC_W'(taps_r) > TC_W'(MAX_TAPS)) begin
      ntap = TAP_W'(MAX_TAPS);
    end else begin
      ntap = TAP_W'(taps_r);
    end
    dly_mod = SUM_W'(delay_r);
    if (dly_mod >= SUM_W'(HISTORY_DEPTH)) begin
      dly_mod = dly_mod - SUM_W'(HISTORY_DEPTH);
    end
  end

  // Next lag, the tap's position and the next write position, all modulo
  // the region depth.
  always_comb begin
    lag_sum = SUM_W'(lag_r) + SUM_W'(dly_r);
    if (lag_sum >= SUM_W'(HISTORY_DEPTH)) begin
      lag_sum = lag_sum - SUM_W'(HISTORY_DEPTH);
    end
    lag_nxt = lag_sum[AW-1:0];
    if (SUM_W'(wpc_r) >= SUM_W'(lag_r)) begin
      idx = SUM_W'(wpc_r) - SUM_W'(lag_r);
    end else begin
      idx = SUM_W'(wpc_r) + SUM_W'(HISTORY_DEPTH) - SUM_W'(lag_r);
    end
    wp_nxt = (wpc_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wpc_r + 1'b1;
  end

  // Memory port selection: clearing pass, sample store or tap read.
  assign base      = MAW'(ch_r) * MAW'(HISTORY_DEPTH);
  assign mem_we    = (st_r == ST_CLR) || (st_r == ST_WR);
  assign mem_waddr = (st_r == ST_CLR) ? clr_addr_r : base + MAW'(wpc_r);
  assign mem_wdata = (st_r == ST_CLR) ? '0 : x_r;
  assign mem_raddr = base + MAW'(idx);

  nme_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Gain power update and the weighted tap.
  assign pg       = p_r * g_r;
  assign tap_prod = $signed(mem_rdata) * $signed({1'b0, p_r});

  nme_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DEN_W       (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == ST_DVS),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer and write positions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLR;
      clr_addr_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c] <= '0;
      end
    end else begin
      unique case (st_r)
        ST_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == MAW'(MEM_DEPTH - 1)) begin
            st_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            st_r <= ST_WR;
          end
        end
        ST_WR: begin
          wp_r[ch_r] <= wp_nxt;
          st_r       <= ST_RD;
        end
        ST_RD: begin
          st_r <= ST_ACC;
        end
        ST_ACC: begin
          st_r <= (j_r == ntap_r) ? ST_DVS : ST_RD;
        end
        ST_DVS: begin
          st_r <= ST_DVW;
        end
        ST_DVW: begin
          if (div_done) begin
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // Working data: latched on accept, then stepped once per tap.
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r   <= CH_W'((CHANNELS == 1) ? 1'b0 : in_ch);
      chf_r  <= in_ch;
      x_r    <= in_smp;
      wpc_r  <= wp_r[(CHANNELS == 1) ? '0 : CH_W'(in_ch)];
      dly_r  <= dly_mod[AW-1:0];
      lag_r  <= dly_mod[AW-1:0];
      g_r    <= g_sat;
      ntap_r <= ntap;
      j_r    <= TAP_W'(1);
      p_r    <= Q15_ONE;
      num_r  <= NUM_W'(in_smp) <<< Q15_SHIFT;
      den_r  <= DEN_W'(Q15_ONE);
    end else if (st_r == ST_RD) begin
      p_r <= pg[GAIN_W+Q15_SHIFT-1:Q15_SHIFT];
    end else if (st_r == ST_ACC) begin
      num_r <= num_r + NUM_W'(tap_prod);
      den_r <= den_r + DEN_W'(p_r);
      lag_r <= lag_nxt;
      j_r   <= j_r + 1'b1;
    end
  end

  // Output register: holds a finished beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_OUT && out_free) begin
      out_ch_r  <= chf_r;
      out_smp_r <= div_quot;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'({out_smp_r, out_ch_r});

endmodule

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nme_pkg::*;

  localparam int CHANNELS   = 2;
  localparam int DEPTH      = 16384;
  localparam int MAX_TAPS   = 8;
  localparam int DATA_W     = 24;
  localparam int LONG_HOLD  = 1500;
  localparam int IDLE_LIMIT = 150000;
  localparam int RAND_SETS  = 8;
  localparam int SET_BEATS  = 128;
  // Index with no register behind it; a write there must change nothing.
  localparam reg_idx_t REG_UNUSED = 2'd3;

  // One result beat, lowest bit first: channel, sample, zero fill.
  typedef struct packed {
    logic [6:0]         fill;
    logic signed [15:0] sample;
    logic               ch;
  } echo_beat_t;

  // Tracks the delay lines and settings of the block and checks its results.
  class echo_tracker;
    delay_t      delay;
    gain_t       gain;
    tapcnt_t     taps;
    int          hist [CHANNELS][DEPTH];
    int unsigned wr_pos [CHANNELS];
    echo_beat_t  pending_echoes[$];
    int          mismatches;
    int          checked;

    function new();
      delay = DELAY_RST;
      gain  = GAIN_RST;
      taps  = TAPS_RST;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ECHO_DELAY: delay = val[DELAY_W-1:0];
        REG_ECHO_GAIN:  gain  = val[GAIN_W-1:0];
        REG_TAP_COUNT:  taps  = val[TAPCNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Stores the sample and works out the normalised sum of its echoes.
    function void take_sample(logic ch, logic [15:0] raw);
      int unsigned    wp, lag, idx, g, ntaps, j;
      longint unsigned p;
      longint         num, den, quo;
      int             x;
      echo_beat_t     e;
      x     = int'($signed(raw));
      wp    = wr_pos[ch];
      g     = (gain > Q15_ONE) ? int'(Q15_ONE) : int'(gain);
      ntaps = (taps == 0) ? 1 : ((taps > MAX_TAPS) ? MAX_TAPS : int'(taps));
      hist[ch][wp] = x;
      num = longint'(x) * 32768;
      den = 32768;
      p   = 32768;
      for (j = 1; j <= ntaps; j++) begin
        lag = (j * delay) % DEPTH;
        idx = (wp + DEPTH - lag) % DEPTH;
        p   = (p * g) >> Q15_SHIFT;
        num += longint'(hist[ch][idx]) * longint'(p);
        den += longint'(p);
      end
      quo = num / den;
      if (quo < -32768) quo = -32768;
      if (quo > 32767) quo = 32767;
      wr_pos[ch] = (wp + 1) % DEPTH;
      e.fill   = '0;
      e.sample = quo[15:0];
      e.ch     = ch;
      pending_echoes.push_back(e);
    endfunction

    // Compares a result beat with the oldest outstanding prediction.
    function void check_echo(echo_beat_t got);
      echo_beat_t want;
      checked++;
      if (pending_echoes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: ch %0d sample %0d", got.ch, got.sample);
        return;
      end
      want = pending_echoes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected ch %0d sample %0d fill %0h, ",
                    "got ch %0d sample %0d fill %0h"},
                   want.ch, want.sample, want.fill, got.ch, got.sample, got.fill);
      end
    endfunction

    function int outstanding();
      return pending_echoes.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [DATA_W-1:0]     out_tdata;
  logic                  cfg_we;
  reg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  echo_tracker tracker = new();
  bit          calm;
  bit          hold_out;
  int          beats_in;
  int          settings_used;
  int          idle_cycles;

  normalized_multitap_echo_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Full-range samples, rail values and held values for runs of constant input.
  function automatic logic [15:0] pick_sample(logic [15:0] prev);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom);
    if (r == 6) return 16'h7fff;
    if (r == 7) return 16'h8000;
    return prev;
  endfunction

  // Sample every beat on either side at the clock edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        tracker.take_sample(in_tdata[0], in_tdata[16:1]);
        beats_in++;
      end
      if (out_tvalid && out_tready)
        tracker.check_echo(echo_beat_t'(out_tdata));
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a beat", idle_cycles);
      $display("FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int wait_left;
    wait_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_out  = 1'b0;
        wait_left = LONG_HOLD;
      end else if (wait_left == 0 && !calm && $urandom_range(0, 99) < 30)
        wait_left = pick_gap();
      if (wait_left > 0) begin
        out_tready <= 1'b0;
        wait_left--;
      end else
        out_tready <= 1'b1;
    end
  end

  task automatic send_sample(logic ch, logic [15:0] s);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, s, ch};
    do @(posedge clk); while (!in_tready);
  endtask

  // Lowers the input valid and waits until every result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    // Let the last accepted beat reach the scoreboard before counting.
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers and pokes the spare index; only called when idle.
  task automatic program_echo(logic [15:0] d, logic [15:0] g, logic [15:0] t);
    reg_idx_t             idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_ECHO_DELAY, REG_ECHO_GAIN, REG_TAP_COUNT, REG_UNUSED};
    val = '{d, g, t, 16'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      tracker.set_reg(idx[k], val[k]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [15:0] d, g, t, s;
    int          r;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_ECHO_DELAY;
    cfg_wdata  <= '0;
    calm       = 1'b0;
    hold_out   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: rails, zero and other values, alternating between the channels.
    send_sample(1'b0, 16'h0000);
    send_sample(1'b1, 16'h7fff);
    send_sample(1'b0, 16'h8000);
    send_sample(1'b1, 16'hffff);
    send_sample(1'b0, 16'h0001);
    send_sample(1'b1, 16'h5555);
    drain();

    // Gain above one with all eight taps one sample apart: rails held constant.
    program_echo(16'd1, 16'hffff, 16'd8);
    for (int k = 0; k < 8; k++)
      send_sample(k[0], k[0] ? 16'h8000 : 16'h7fff);
    drain();

    // Delay zero (upper write bits dropped), zero gain, tap count zero.
    program_echo(16'h0800, 16'd0, 16'd0);
    send_sample(1'b0, 16'h7fff);
    send_sample(1'b1, 16'h8000);
    send_sample(1'b0, 16'haaaa);
    send_sample(1'b1, 16'h0001);
    drain();

    // Widest spacing, unity gain, tap count above the maximum.
    program_echo(16'd2047, 16'd32768, 16'hffff);
    send_sample(1'b0, 16'h8000);
    send_sample(1'b1, 16'h7fff);
    send_sample(1'b0, 16'h1234);
    send_sample(1'b1, 16'hedcb);
    drain();

    // Random settings, each followed by a burst of random samples.
    s = '0;
    for (int p = 0; p < RAND_SETS; p++) begin
      r = $urandom_range(0, 9);
      if (r < 7) d = 16'($urandom_range(1, 16));
      else if (r < 9) d = 16'($urandom_range(17, 300));
      else d = 16'($urandom);
      r = $urandom_range(0, 9);
      if (r < 2) g = 16'd32768;
      else if (r < 3) g = 16'($urandom_range(32769, 65535));
      else g = 16'($urandom_range(0, 32767));
      r = $urandom_range(0, 9);
      if (r < 8) t = 16'($urandom_range(1, 8));
      else t = 16'($urandom);
      program_echo(d, g, t);
      calm = (p == 2);
      // Hold the receiver off long enough for the input to back up.
      if (p == 4) hold_out = 1'b1;
      for (int k = 0; k < SET_BEATS; k++) begin
        s = pick_sample(s);
        send_sample(1'($urandom_range(0, 1)), s);
      end
      drain();
      calm = 1'b0;
    end

    repeat (100) @(posedge clk);
    $display("Sent %0d samples under %0d register settings besides reset values.",
             beats_in, settings_used);
    $display("Checked %0d result beats, %0d mismatches, %0d still outstanding.",
             tracker.checked, tracker.mismatches, tracker.outstanding());
    if (tracker.mismatches == 0 && tracker.outstanding() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
